// ===== rtl/bwrw_pkg.sv =====
`default_nettype none
// ============================================================================
// bwrw_pkg: shared types and constants for the banked work-RAM window
// Slot entry layout, opcodes, region codes and the reset mapping of the
// slot table.
// ============================================================================
package bwrw_pkg;

    localparam int CHUNK_BYTES  = 256;
    localparam int SLOT_COUNT   = 256;
    localparam int STORE_BYTES  = 32768;

    localparam int CHUNK_W      = $clog2(CHUNK_BYTES);
    localparam int SLOT_W       = $clog2(SLOT_COUNT);
    localparam int STORE_ADDR_W = $clog2(STORE_BYTES);

    // Largest bank is 16 KB (size code six).
    localparam int MAX_CODE     = 6;
    localparam int MAX_BANK     = 256 << MAX_CODE;
    localparam int COUNT_W      = $clog2(MAX_BANK / CHUNK_BYTES + 1);
    localparam int CHUNK_IDX_W  = 8 + COUNT_W;
    localparam int SIZE_W       = 17;

    localparam int CFG_INDEX_W  = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NVRAM_BYTES = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_RAM_BYTES   = CFG_INDEX_W'(1);

    localparam logic [1:0] REGION_WHOLE = 2'd0;
    localparam logic [1:0] REGION_RAM   = 2'd1;
    localparam logic [1:0] REGION_NVRAM = 2'd2;
    localparam logic [1:0] REGION_NONE  = 2'd3;

    // Reset mapping: 8K bank 0 of the whole store at 0x6000.
    localparam int RESET_ADDR   = 'h6000;
    localparam int RESET_BANK   = 'h2000;
    localparam int RESET_SIZE   = 'h2000;

    typedef enum logic [2:0] {
        OP_READ    = 3'd0,
        OP_WRITE   = 3'd1,
        OP_MAP     = 3'd2,
        OP_DISABLE = 3'd3,
        OP_DREAD   = 3'd4,
        OP_DWRITE  = 3'd5
    } opcode_t;

    typedef struct packed {
        logic                    valid;
        logic                    readable;
        logic                    writable;
        logic [STORE_ADDR_W-1:0] base;
        logic [CHUNK_W-1:0]      mask;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

    function automatic slot_entry_t reset_entry(input logic [SLOT_W-1:0] slot);
        slot_entry_t       e;
        logic [SLOT_W-1:0] rel;
        e   = '0;
        rel = slot - SLOT_W'(RESET_ADDR >> CHUNK_W);
        if (32'(rel) < (RESET_BANK / CHUNK_BYTES)) begin
            e.valid    = 1'b1;
            e.readable = 1'b1;
            e.writable = 1'b1;
            e.base     = STORE_ADDR_W'((32'(rel) << CHUNK_W) & (RESET_SIZE - 1));
            e.mask     = CHUNK_W'((CHUNK_BYTES - 1) & (RESET_SIZE - 1));
        end
        return e;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/bwrw_ram.sv =====
`default_nettype none
// ============================================================================
// bwrw_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle.
// ============================================================================
module bwrw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/banked_work_ram_window_core.sv =====
`default_nettype none
// ============================================================================
// banked_work_ram_window_core: CPU window of chunk slots over a byte store
// Slot table and byte store live in synchronous RAMs; a small sequencer
// looks up the slot, then accesses the store or walks the slot table.
// ============================================================================
// Sequence, start to done: a served read or direct read passes slot read,
//   store read and result; a miss, a write or an unused opcode ends after the
//   slot read; map and disable then walk every slot the bank covers.
// Throughput: one word at a time; the next start is taken in the done cycle.
//   Results show for one cycle on done; the receiver cannot stall.
// Reset: after rst_n rises, a clearing pass zeroes the whole store and
//   loads the slot table reset mapping; busy stays high meanwhile.
module banked_work_ram_window_core
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // command
    input  wire logic                            start,
    output      logic                            busy,
    input  wire logic [2:0]                      opcode,
    input  wire logic [15:0]                     address,
    input  wire logic [7:0]                      write_data,
    input  wire logic [7:0]                      bank_number,
    input  wire logic [2:0]                      bank_size_code,
    input  wire logic [1:0]                      region_select,
    input  wire logic                            allow_read,
    input  wire logic                            allow_write,
    input  wire logic [7:0]                      open_bus,
    // result
    output      logic                            done,
    output      logic [7:0]                      read_data,
    output      logic                            served,
    output      logic                            slot_writable,
    // configuration
    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic [bwrw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [15:0]                     cfg_data
);

    import bwrw_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_STORE_RD,
        ST_MAP
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [15:0] nvram_bytes_reg;
    logic [15:0] ram_bytes_reg;

    // latched command word
    logic [2:0]             op_reg;
    logic [15:0]            addr_reg;
    logic [7:0]             wdata_reg;
    logic [7:0]             bank_reg;
    logic [2:0]             code_reg;
    logic [1:0]             region_reg;
    logic                   rd_reg;
    logic                   wr_reg;
    logic [7:0]             open_bus_reg;
    logic                   lookup_wr_reg;

    // clearing pass and map walk counters
    logic [STORE_ADDR_W-1:0] clr_reg;
    logic [COUNT_W-1:0]      idx_reg;

    // result registers
    logic       done_reg;
    logic [7:0] read_data_reg;
    logic       served_reg;
    logic       slot_writable_reg;

    // RAM ports
    logic                    slot_we;
    logic [SLOT_W-1:0]       slot_waddr;
    slot_entry_t             slot_wdata;
    logic [SLOT_W-1:0]       slot_raddr;
    logic [ENTRY_W-1:0]      slot_rdata;
    slot_entry_t             entry;

    logic                    store_we;
    logic [STORE_ADDR_W-1:0] store_waddr;
    logic [7:0]              store_wdata;
    logic [STORE_ADDR_W-1:0] store_raddr;
    logic [7:0]              store_rdata;

    // derived values
    logic [SIZE_W-1:0]       total;
    logic [SIZE_W-1:0]       total_m1;
    logic [SIZE_W-1:0]       size;
    logic [SIZE_W-1:0]       size_m1;
    logic [15:0]             region_start;
    logic [SIZE_W-1:0]       bank_bytes;
    logic [COUNT_W-1:0]      count;
    logic [CHUNK_IDX_W-1:0]  chunk;
    logic [SIZE_W-1:0]       chunk_off;
    slot_entry_t             map_entry;
    logic [SLOT_W-1:0]       first_slot;
    logic [STORE_ADDR_W-1:0] slot_addr;
    logic [STORE_ADDR_W-1:0] direct_addr;
    logic [15:0]             masked_addr;
    logic                    accept;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    assign done          = done_reg;
    assign read_data     = read_data_reg;
    assign served        = served_reg;
    assign slot_writable = slot_writable_reg;

    assign entry = slot_entry_t'(slot_rdata);

    // Region size and start, from configuration and the latched region code.
    assign total    = SIZE_W'(nvram_bytes_reg) + SIZE_W'(ram_bytes_reg);
    assign total_m1 = total - SIZE_W'(1);

    always_comb
    begin
        size         = '0;
        region_start = '0;
        case (region_reg)
            REGION_WHOLE:
            begin
                size = total;
            end
            REGION_RAM:
            begin
                size         = SIZE_W'(ram_bytes_reg);
                region_start = nvram_bytes_reg;
            end
            REGION_NVRAM:
            begin
                size = SIZE_W'(nvram_bytes_reg);
            end
            default:
            begin
                size = '0;
            end
        endcase
    end

    assign size_m1 = size - SIZE_W'(1);

    // Slots covered by the bank, and the entry for slot idx of the walk.
    assign bank_bytes = SIZE_W'(256) << code_reg;
    assign count      = COUNT_W'(bank_bytes >> CHUNK_W);
    assign chunk      = (CHUNK_IDX_W'(bank_reg) * CHUNK_IDX_W'(count))
                        | CHUNK_IDX_W'(idx_reg);
    assign chunk_off  = SIZE_W'({chunk, {CHUNK_W{1'b0}}}) & size_m1;
    assign first_slot = SLOT_W'(addr_reg >> CHUNK_W);

    always_comb
    begin
        map_entry = '0;
        if (size != '0)
        begin
            map_entry.valid    = 1'b1;
            map_entry.readable = rd_reg;
            map_entry.writable = wr_reg;
            map_entry.base     = STORE_ADDR_W'(SIZE_W'(region_start) + chunk_off);
            map_entry.mask     = CHUNK_W'(size_m1);
        end
    end

    // Store addresses for slot-mapped and direct accesses.
    assign masked_addr = addr_reg & 16'(entry.mask);
    assign slot_addr   = entry.base + STORE_ADDR_W'(masked_addr);
    assign direct_addr = STORE_ADDR_W'(SIZE_W'(addr_reg) & total_m1);

    // Slot table port: clearing pass loads the reset map, map walk updates.
    assign slot_raddr = SLOT_W'(address >> CHUNK_W);

    always_comb
    begin
        slot_we    = 1'b0;
        slot_waddr = first_slot + SLOT_W'(idx_reg);
        slot_wdata = map_entry;
        if (state_reg == ST_CLEAR)
        begin
            slot_we    = (32'(clr_reg) < SLOT_COUNT);
            slot_waddr = SLOT_W'(clr_reg);
            slot_wdata = reset_entry(SLOT_W'(clr_reg));
        end
        else if (state_reg == ST_MAP)
        begin
            slot_we = 1'b1;
        end
    end

    // Store port: zero during the clearing pass, else the write in lookup.
    always_comb
    begin
        store_we    = 1'b0;
        store_waddr = slot_addr;
        store_wdata = wdata_reg;
        store_raddr = slot_addr;
        if (state_reg == ST_CLEAR)
        begin
            store_we    = 1'b1;
            store_waddr = clr_reg;
            store_wdata = '0;
        end
        else if (state_reg == ST_LOOKUP)
        begin
            case (opcode_t'(op_reg))
                OP_WRITE:
                begin
                    store_we = entry.valid && entry.writable;
                end
                OP_DREAD:
                begin
                    store_raddr = direct_addr;
                end
                OP_DWRITE:
                begin
                    store_we    = (total != '0);
                    store_waddr = direct_addr;
                end
                default:
                begin
                    store_we = 1'b0;
                end
            endcase
        end
    end

    bwrw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    bwrw_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    // Sequencer: state, counters, latched word and registered results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            clr_reg           <= '0;
            idx_reg           <= '0;
            nvram_bytes_reg   <= '0;
            ram_bytes_reg     <= 16'(RESET_SIZE);
            done_reg          <= 1'b0;
            read_data_reg     <= '0;
            served_reg        <= 1'b0;
            slot_writable_reg <= 1'b0;
            op_reg            <= '0;
            addr_reg          <= '0;
            wdata_reg         <= '0;
            bank_reg          <= '0;
            code_reg          <= '0;
            region_reg        <= '0;
            rd_reg            <= 1'b0;
            wr_reg            <= 1'b0;
            open_bus_reg      <= '0;
            lookup_wr_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_NVRAM_BYTES: nvram_bytes_reg <= cfg_data;
                    CFG_RAM_BYTES:   ram_bytes_reg   <= cfg_data;
                    default:         ;
                endcase
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + STORE_ADDR_W'(1);
                    if (clr_reg == {STORE_ADDR_W{1'b1}})
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg       <= opcode;
                        addr_reg     <= address;
                        wdata_reg    <= write_data;
                        bank_reg     <= bank_number;
                        // saturate size code seven to 16 KB
                        code_reg     <= (bank_size_code > 3'(MAX_CODE)) ?
                                        3'(MAX_CODE) : bank_size_code;
                        // disable maps as a region with no size
                        region_reg   <= (opcode == 3'(OP_DISABLE)) ?
                                        REGION_NONE : region_select;
                        rd_reg       <= allow_read;
                        wr_reg       <= allow_write;
                        open_bus_reg <= open_bus;
                        idx_reg      <= '0;
                        state_reg    <= ST_LOOKUP;
                    end
                end

                ST_LOOKUP:
                begin
                    lookup_wr_reg     <= entry.writable;
                    slot_writable_reg <= entry.writable;
                    read_data_reg     <= '0;
                    served_reg        <= 1'b0;
                    state_reg         <= ST_IDLE;
                    done_reg          <= 1'b1;
                    case (opcode_t'(op_reg))
                        OP_READ:
                        begin
                            if (entry.valid && entry.readable)
                            begin
                                state_reg <= ST_STORE_RD;
                                done_reg  <= 1'b0;
                            end
                            else
                            begin
                                read_data_reg <= open_bus_reg;
                            end
                        end
                        OP_WRITE:
                        begin
                            served_reg <= entry.valid && entry.writable;
                        end
                        OP_MAP, OP_DISABLE:
                        begin
                            // bank smaller than a chunk leaves the table alone
                            if (count != '0)
                            begin
                                state_reg <= ST_MAP;
                                done_reg  <= 1'b0;
                            end
                        end
                        OP_DREAD:
                        begin
                            if (total != '0)
                            begin
                                state_reg <= ST_STORE_RD;
                                done_reg  <= 1'b0;
                            end
                            else
                            begin
                                read_data_reg <= open_bus_reg;
                            end
                        end
                        OP_DWRITE:
                        begin
                            served_reg <= (total != '0);
                        end
                        default:
                        begin
                            served_reg <= 1'b0;
                        end
                    endcase
                end

                ST_STORE_RD:
                begin
                    read_data_reg     <= store_rdata;
                    served_reg        <= 1'b1;
                    slot_writable_reg <= lookup_wr_reg;
                    done_reg          <= 1'b1;
                    state_reg         <= ST_IDLE;
                end

                ST_MAP:
                begin
                    // advance one slot per cycle; the first slot holds address
                    idx_reg <= idx_reg + COUNT_W'(1);
                    if (idx_reg == count - COUNT_W'(1))
                    begin
                        read_data_reg     <= '0;
                        served_reg        <= 1'b0;
                        slot_writable_reg <= (size != '0) && wr_reg;
                        done_reg          <= 1'b1;
                        state_reg         <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
